/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the nonce tester RTL.
// Every check is clocked on clk and is ignored while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on the rising edge of clk, outside of reset.
`define KPNT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next one.
`define KPNT_ASSERT_NEXT(lbl, cond, cons, msg) \
  `KPNT_ASSERT(lbl, (cond) |=> (cons), msg)

`endif

/* hw/rtl/kpnt_pkg.sv */
`timescale 1ns / 1ps

package kpnt_pkg;

  localparam int unsigned LANE_W       = 64;
  localparam int unsigned LANES        = 25;
  localparam int unsigned ROUNDS       = 12;
  localparam int unsigned HEADER_WORDS = 10;
  localparam int unsigned HDR_IDX_W    = 4;

  // Lanes that carry the nonce, the fixed padding and the hash word that is compared.
  localparam int unsigned NONCE_LANE_A = 4;
  localparam int unsigned NONCE_LANE_B = 5;
  localparam int unsigned PAD_LANE_A   = 10;
  localparam int unsigned PAD_LANE_B   = 20;
  localparam int unsigned HASH_LANE    = 3;

  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [LANES-1:0][LANE_W-1:0] state_t;

  // Request kind carried in tuser.
  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TRY  = 1'b1
  } func_t;

  localparam lane_t PAD_A_VALUE = 64'h0000_0000_0000_0700;
  localparam lane_t PAD_B_VALUE = 64'h8000_0000_0000_0000;

  // Round constants of the twelve rounds, in the order they are applied.
  localparam lane_t RC [ROUNDS] = '{
    64'h0000_0000_8000_808B, 64'h8000_0000_0000_008B, 64'h8000_0000_0000_8089,
    64'h8000_0000_0000_8003, 64'h8000_0000_0000_8002, 64'h8000_0000_0000_0080,
    64'h0000_0000_0000_800A, 64'h8000_0000_8000_000A, 64'h8000_0000_8000_8081,
    64'h8000_0000_0000_8080, 64'h0000_0000_8000_0001, 64'h8000_0000_8000_8008
  };

  // Rotation offset of lane x + 5y.
  localparam int unsigned ROT_OFFS [LANES] = '{
     0,  1, 62, 28, 27,
    36, 44,  6, 55, 20,
     3, 10, 43, 25, 39,
    41, 45, 15, 21,  8,
    18,  2, 61, 56, 14
  };

  // Left rotation by an offset fixed at elaboration.
  function automatic lane_t rotl(lane_t v, int unsigned n);
    if (n == 0) begin
      return v;
    end
    return (v << n) | (v >> (LANE_W - n));
  endfunction

  // One round: theta, rho-pi, chi and iota.
  function automatic state_t keccak_round(state_t a_in, lane_t rc);
    lane_t  c [5];
    lane_t  d [5];
    state_t a;
    state_t b;
    state_t o;
    a = a_in;
    for (int x = 0; x < 5; x++) begin
      c[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
    end
    for (int x = 0; x < 5; x++) begin
      d[x] = c[(x+4)%5] ^ rotl(c[(x+1)%5], 1);
    end
    for (int i = 0; i < LANES; i++) begin
      a[i] = a[i] ^ d[i%5];
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        b[y + 5*((2*x + 3*y) % 5)] = rotl(a[x + 5*y], ROT_OFFS[x + 5*y]);
      end
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        o[x + 5*y] = b[x + 5*y] ^ (~b[(x+1)%5 + 5*y] & b[(x+2)%5 + 5*y]);
      end
    end
    o[0] = o[0] ^ rc;
    return o;
  endfunction

endpackage

/* hw/rtl/keccak_p1600_12_nonce_tester.sv */
// A try request passes 14 register stages (built state, twelve rounds, compare),
// and its result shows on out_tvalid from the output register of the compare stage.
// One request per cycle while the pipeline is not stalled; each of the twelve rounds has its own stage.
// A stall on the result side holds the whole pipeline; load requests give no result.
// Reset (rst_n low, synchronous) clears valid bits and target; header words stay unset.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module keccak_p1600_12_nonce_tester
  import kpnt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Request channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // word_index[3:0], word_value[67:4], nonce[131:68]
  input  logic         in_tuser,   // func[0]
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // nonce_out[63:0], hash_word[127:64]
  output logic         out_tuser,  // found[0]
  // Target register write.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data
);

  logic                  adv;
  logic                  in_acc;
  logic [HDR_IDX_W-1:0]  in_word_index;
  lane_t                 in_word_value;
  lane_t                 in_nonce;
  lane_t                 target_r;
  lane_t                 hdr_r [HEADER_WORDS];
  state_t                init_st;
  state_t                st_r [ROUNDS+1];
  lane_t                 nonce_r [ROUNDS+1];
  logic [ROUNDS:0]       vld_r;
  logic                  out_valid_r;
  logic                  out_found_r;
  lane_t                 out_nonce_r;
  lane_t                 out_hash_r;

  // Request fields.
  assign in_word_index = in_tdata[3:0];
  assign in_word_value = in_tdata[67:4];
  assign in_nonce      = in_tdata[131:68];

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Target register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      target_r <= cfg_data;
    end
  end

  // Header word store; indexes past the last word are dropped.
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == FUNC_LOAD) && (in_word_index < HDR_IDX_W'(HEADER_WORDS))) begin
      hdr_r[in_word_index] <= in_word_value;
    end
  end

  // Initial state from the header words, the nonce and the padding.
  always_comb begin
    init_st = '0;
    for (int i = 0; i < HEADER_WORDS; i++) begin
      init_st[i] = hdr_r[i];
    end
    init_st[NONCE_LANE_A] = {in_nonce[7:0], hdr_r[NONCE_LANE_A][55:0]};
    init_st[NONCE_LANE_B] = {hdr_r[NONCE_LANE_B][63:56], in_nonce[63:8]};
    init_st[PAD_LANE_A]   = PAD_A_VALUE;
    init_st[PAD_LANE_B]   = PAD_B_VALUE;
  end

  // Stage 0 takes the built state of a try request.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0]    <= init_st;
      nonce_r[0] <= in_nonce;
    end
  end

  // One round per stage.
  for (genvar s = 0; s < ROUNDS; s++) begin : g_round
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[s+1]    <= keccak_round(st_r[s], RC[s]);
        nonce_r[s+1] <= nonce_r[s];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[ROUNDS-1:0], in_acc && (in_tuser == FUNC_TRY)};
    end
  end

  // Compare stage and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hash_r  <= st_r[ROUNDS][HASH_LANE];
      out_nonce_r <= nonce_r[ROUNDS];
      out_found_r <= st_r[ROUNDS][HASH_LANE] < target_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_hash_r, out_nonce_r};
  assign out_tuser  = out_found_r;

  // A result appears only when the last round stage held a try request.
  `KPNT_ASSERT(a_out_from_pipe, $rose(out_valid_r) |-> $past(vld_r[ROUNDS]), "stray result")
  // A stalled pipeline keeps all valid bits.
  `KPNT_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld_r), "valid bits changed during a stall")
  // A load request never enters the round pipeline.
  `KPNT_ASSERT_NEXT(a_load_no_entry, in_acc && (in_tuser == FUNC_LOAD), !vld_r[0], "load in pipe")

endmodule
